// ===== design/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants for the collinear point filter.
// ----------------------------------------------------------------------------
package cpf_pkg;

    localparam int NUM_JOINTS = 6;
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int UV_W       = SQ_W + 1;
    localparam int SUM_W      = SQ_W + $clog2(NUM_JOINTS);
    localparam int D_W        = SUM_W + 1;
    localparam int TAG_W      = 16;
    localparam int THR_W      = 32;
    localparam int LIM_W      = 20;
    localparam int LIM2_W     = 2 * LIM_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_A_W    = 2 * SUM_W;
    localparam int MUL_B_W    = 64;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = MUL_B_W / DIGIT_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int CMP_SHIFT  = 60;

    localparam logic signed [THR_W-1:0] COS_THRESHOLD_RESET = 32'sd1073688042;
    localparam logic [LIM_W-1:0]        ZERO_LIMIT_RESET    = 20'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_THRESHOLD    = 8'd0,
        REG_ZERO_LENGTH_LIMIT = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PHASE_EMPTY  = 2'd0,
        PHASE_ANCHOR = 2'd1,
        PHASE_HELD   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_DOT_SQ = 2'd0,
        OP_PQ     = 2'd1,
        OP_THR_SQ = 2'd2,
        OP_RHS    = 2'd3
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PROD,
        ST_SUM,
        ST_CHECK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_EMIT_HELD,
        ST_COMMIT,
        ST_EMIT_NEW
    } state_t;

    typedef struct packed {
        logic [SQ_W-1:0]        uu;
        logic [SQ_W-1:0]        vv;
        logic signed [UV_W-1:0] uv;
    } lane_prod_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_res_t;

endpackage

// ===== design/cpf_lane.sv =====
// ----------------------------------------------------------------------------
// cpf_lane
// One joint lane: step differences and their registered products.
// ----------------------------------------------------------------------------
module cpf_lane (
    input  logic                                clk,
    input  logic signed [cpf_pkg::COORD_W-1:0]  anchor,
    input  logic signed [cpf_pkg::COORD_W-1:0]  held,
    input  logic signed [cpf_pkg::COORD_W-1:0]  cur,
    output cpf_pkg::lane_prod_t                 prod
);
    import cpf_pkg::*;

    logic signed [DIFF_W-1:0]   u;
    logic signed [DIFF_W-1:0]   v;
    logic signed [2*DIFF_W-1:0] uu_full;
    logic signed [2*DIFF_W-1:0] vv_full;
    logic signed [2*DIFF_W-1:0] uv_full;
    lane_prod_t                 prod_reg;

    always_comb
    begin
        u       = DIFF_W'(held) - DIFF_W'(anchor);
        v       = DIFF_W'(cur) - DIFF_W'(held);
        uu_full = u * u;
        vv_full = v * v;
        uv_full = u * v;
    end

    always_ff @(posedge clk)
    begin
        prod_reg.uu <= uu_full[SQ_W-1:0];
        prod_reg.vv <= vv_full[SQ_W-1:0];
        prod_reg.uv <= uv_full[UV_W-1:0];
    end

    assign prod = prod_reg;

endmodule

// ===== design/cpf_merge.sv =====
// ----------------------------------------------------------------------------
// cpf_merge
// Sums the lane products into the two squared step lengths and the dot product.
// ----------------------------------------------------------------------------
module cpf_merge (
    input  logic                              clk,
    input  cpf_pkg::lane_prod_t               prods [cpf_pkg::NUM_JOINTS],
    output logic [cpf_pkg::SUM_W-1:0]         p_sum,
    output logic [cpf_pkg::SUM_W-1:0]         q_sum,
    output logic signed [cpf_pkg::D_W-1:0]    d_sum
);
    import cpf_pkg::*;

    logic [SUM_W-1:0]        p_next;
    logic [SUM_W-1:0]        q_next;
    logic signed [D_W-1:0]   d_next;
    logic [SUM_W-1:0]        p_reg;
    logic [SUM_W-1:0]        q_reg;
    logic signed [D_W-1:0]   d_reg;

    always_comb
    begin
        p_next = '0;
        q_next = '0;
        d_next = '0;
        for (int k = 0; k < NUM_JOINTS; k++)
        begin
            p_next = p_next + SUM_W'(prods[k].uu);
            q_next = q_next + SUM_W'(prods[k].vv);
            d_next = d_next + D_W'(prods[k].uv);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign p_sum = p_reg;
    assign q_sum = q_reg;
    assign d_sum = d_reg;

endmodule

// ===== design/cpf_mul_seq.sv =====
// ----------------------------------------------------------------------------
// cpf_mul_seq
// Digit-serial unsigned multiplier, one 8-bit digit of the multiplier a cycle.
// ----------------------------------------------------------------------------
module cpf_mul_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cpf_pkg::MUL_A_W-1:0]   a,
    input  logic [cpf_pkg::MUL_B_W-1:0]   b,
    output cpf_pkg::mul_res_t             res
);
    import cpf_pkg::*;

    localparam int CNT_W = $clog2(NUM_DIGITS);

    logic [MUL_A_W-1:0]         a_reg;
    logic [MUL_B_W-1:0]         b_reg;
    logic [PROD_W-1:0]          acc_reg;
    logic [PROD_W-1:0]          acc_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [MUL_A_W+DIGIT_W-1:0] partial;

    always_comb
    begin
        partial  = a_reg * b_reg[MUL_B_W-1 -: DIGIT_W];
        acc_next = (acc_reg << DIGIT_W) + PROD_W'(partial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            b_reg   <= b_reg << DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    assign res.done = done_reg;
    assign res.prod = acc_reg;

endmodule

// ===== design/collinear_point_filter.sv =====
// ----------------------------------------------------------------------------
// collinear_point_filter
// Streaming removal of collinear polyline points with an exact turn test.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   joint_0..joint_5, point_tag, last_point
// out      output     out_valid / out_stall out_joint_0..out_joint_5, out_tag, out_last
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One point is processed at a time; a new request is taken only in the idle state.
// The first point of a stream is always emitted; a second point is held, or emitted when last.
// A later point skips the exact test when a step is short or the signs decide it;
// otherwise the exact cosine compare runs four products through the 8-bit digit
// multiplier. Each emit waits while the output is full and stalled.
// Reset is asynchronous; it clears the control state and sets the configuration
// registers to their reset values.
// ----------------------------------------------------------------------------
module collinear_point_filter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_0,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_1,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_2,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_3,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_4,
    input  logic signed [cpf_pkg::COORD_W-1:0]      joint_5,
    input  logic [cpf_pkg::TAG_W-1:0]               point_tag,
    input  logic                                    last_point,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_0,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_1,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_2,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_3,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_4,
    output logic signed [cpf_pkg::COORD_W-1:0]      out_joint_5,
    output logic [cpf_pkg::TAG_W-1:0]               out_tag,
    output logic                                    out_last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cpf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [cpf_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import cpf_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    phase_t                     phase_reg;
    mul_op_t                    op_reg;

    logic signed [THR_W-1:0]    thr_reg;
    logic [LIM_W-1:0]           lim_reg;
    logic [LIM2_W-1:0]          lim2_reg;

    logic signed [COORD_W-1:0]  in_coords [NUM_JOINTS];
    logic signed [COORD_W-1:0]  cur_reg [NUM_JOINTS];
    logic signed [COORD_W-1:0]  held_reg [NUM_JOINTS];
    logic signed [COORD_W-1:0]  anchor_reg [NUM_JOINTS];
    logic [TAG_W-1:0]           cur_tag_reg;
    logic [TAG_W-1:0]           held_tag_reg;
    logic                       cur_last_reg;

    logic signed [COORD_W-1:0]  out_coords_reg [NUM_JOINTS];
    logic [TAG_W-1:0]           out_tag_reg;
    logic                       out_last_reg;
    logic                       out_valid_reg;

    lane_prod_t                 prods [NUM_JOINTS];
    logic [SUM_W-1:0]           p_sum;
    logic [SUM_W-1:0]           q_sum;
    logic signed [D_W-1:0]      d_sum;

    logic [MUL_A_W-1:0]         m1_reg;
    logic [MUL_A_W-1:0]         m2_reg;
    logic [MUL_B_W-1:0]         m3_reg;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    mul_res_t                   mul_res;

    logic                       accept;
    logic                       slot_free;
    logic                       out_load;
    logic                       emit_held;
    logic                       mul_start;
    logic [D_W-1:0]             d_abs;
    logic [THR_W-1:0]           t_abs;
    logic                       short_step;
    logic                       thr_nonpos;
    logic                       thr_nonneg;
    logic                       quick_col;
    logic                       quick_sep;
    logic [PROD_W-1:0]          lhs;
    logic                       big_col;

    assign in_coords[0] = joint_0;
    assign in_coords[1] = joint_1;
    assign in_coords[2] = joint_2;
    assign in_coords[3] = joint_3;
    assign in_coords[4] = joint_4;
    assign in_coords[5] = joint_5;

    genvar g;
    generate
        for (g = 0; g < NUM_JOINTS; g++)
        begin : g_lane
            cpf_lane u_lane (
                .clk    (clk),
                .anchor (anchor_reg[g]),
                .held   (held_reg[g]),
                .cur    (cur_reg[g]),
                .prod   (prods[g])
            );
        end
    endgenerate

    cpf_merge u_merge (
        .clk   (clk),
        .prods (prods),
        .p_sum (p_sum),
        .q_sum (q_sum),
        .d_sum (d_sum)
    );

    cpf_mul_seq u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .res   (mul_res)
    );

    always_comb
    begin
        d_abs      = d_sum[D_W-1] ? -d_sum : d_sum;
        t_abs      = thr_reg[THR_W-1] ? -thr_reg : thr_reg;
        short_step = (p_sum <= SUM_W'(lim2_reg)) || (q_sum <= SUM_W'(lim2_reg));
        thr_nonpos = thr_reg[THR_W-1] || (thr_reg == '0);
        thr_nonneg = !thr_reg[THR_W-1];
        quick_col  = short_step || (!d_sum[D_W-1] && thr_nonpos);
        quick_sep  = d_sum[D_W-1] && thr_nonneg;
        lhs        = PROD_W'(m1_reg) << CMP_SHIFT;
        if (thr_reg[THR_W-1])
            big_col = lhs <= mul_res.prod;
        else
            big_col = lhs >= mul_res.prod;
    end

    always_comb
    begin
        case (op_reg)
            OP_DOT_SQ:
            begin
                mul_a = MUL_A_W'(d_abs[SUM_W-1:0]);
                mul_b = MUL_B_W'(d_abs[SUM_W-1:0]);
            end
            OP_PQ:
            begin
                mul_a = MUL_A_W'(p_sum);
                mul_b = MUL_B_W'(q_sum);
            end
            OP_THR_SQ:
            begin
                mul_a = MUL_A_W'(t_abs);
                mul_b = MUL_B_W'(t_abs);
            end
            default:
            begin
                mul_a = m2_reg;
                mul_b = m3_reg;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_START;
            ST_START:
                case (phase_reg)
                    PHASE_EMPTY:  state_next = ST_EMIT_NEW;
                    PHASE_ANCHOR: state_next = cur_last_reg ? ST_EMIT_NEW : ST_IDLE;
                    default:      state_next = ST_PROD;
                endcase
            ST_PROD:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_CHECK;
            ST_CHECK:
                if (quick_col)
                    state_next = ST_COMMIT;
                else if (quick_sep)
                    state_next = ST_EMIT_HELD;
                else
                    state_next = ST_MUL_GO;
            ST_MUL_GO:
                state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
                if (mul_res.done)
                begin
                    if (op_reg != OP_RHS)
                        state_next = ST_MUL_GO;
                    else if (big_col)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_EMIT_HELD;
                end
            ST_EMIT_HELD:
                if (slot_free)
                    state_next = ST_COMMIT;
            ST_COMMIT:
                state_next = cur_last_reg ? ST_EMIT_NEW : ST_IDLE;
            ST_EMIT_NEW:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        out_load  = 1'b0;
        emit_held = 1'b0;
        unique case (state_reg)
            ST_IDLE:      in_stall  = 1'b0;
            ST_MUL_GO:    mul_start = 1'b1;
            ST_EMIT_HELD:
            begin
                out_load  = slot_free;
                emit_held = 1'b1;
            end
            ST_EMIT_NEW:  out_load  = slot_free;
            default:      ;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PHASE_EMPTY;
            op_reg        <= OP_DOT_SQ;
            out_valid_reg <= 1'b0;
            thr_reg       <= COS_THRESHOLD_RESET;
            lim_reg       <= ZERO_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COS_THRESHOLD:     thr_reg <= cfg_data[THR_W-1:0];
                    REG_ZERO_LENGTH_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                    default:               ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_CHECK)
                op_reg <= OP_DOT_SQ;
            else if (state_reg == ST_MUL_WAIT && mul_res.done && op_reg != OP_RHS)
                op_reg <= mul_op_t'(op_reg + 2'd1);

            if (state_reg == ST_START)
            begin
                case (phase_reg)
                    PHASE_EMPTY:  phase_reg <= cur_last_reg ? PHASE_EMPTY : PHASE_ANCHOR;
                    PHASE_ANCHOR: phase_reg <= cur_last_reg ? PHASE_EMPTY : PHASE_HELD;
                    default:      ;
                endcase
            end
            else if (state_reg == ST_COMMIT)
                phase_reg <= cur_last_reg ? PHASE_EMPTY : PHASE_HELD;
        end
    end

    always_ff @(posedge clk)
    begin
        lim2_reg <= lim_reg * lim_reg;

        if (accept)
        begin
            cur_reg      <= in_coords;
            cur_tag_reg  <= point_tag;
            cur_last_reg <= last_point;
        end

        if (state_reg == ST_START)
        begin
            if (phase_reg == PHASE_EMPTY)
                anchor_reg <= cur_reg;
            else if (phase_reg == PHASE_ANCHOR)
            begin
                held_reg     <= cur_reg;
                held_tag_reg <= cur_tag_reg;
            end
        end

        if (state_reg == ST_COMMIT)
        begin
            held_reg     <= cur_reg;
            held_tag_reg <= cur_tag_reg;
        end

        if (out_load && emit_held)
            anchor_reg <= held_reg;

        if (state_reg == ST_MUL_WAIT && mul_res.done)
        begin
            case (op_reg)
                OP_DOT_SQ: m1_reg <= mul_res.prod[MUL_A_W-1:0];
                OP_PQ:     m2_reg <= mul_res.prod[MUL_A_W-1:0];
                OP_THR_SQ: m3_reg <= mul_res.prod[MUL_B_W-1:0];
                default:   ;
            endcase
        end

        if (out_load)
        begin
            if (emit_held)
            begin
                out_coords_reg <= held_reg;
                out_tag_reg    <= held_tag_reg;
                out_last_reg   <= 1'b0;
            end
            else
            begin
                out_coords_reg <= cur_reg;
                out_tag_reg    <= cur_tag_reg;
                out_last_reg   <= cur_last_reg;
            end
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_joint_0 = out_coords_reg[0];
    assign out_joint_1 = out_coords_reg[1];
    assign out_joint_2 = out_coords_reg[2];
    assign out_joint_3 = out_coords_reg[3];
    assign out_joint_4 = out_coords_reg[4];
    assign out_joint_5 = out_coords_reg[5];
    assign out_tag     = out_tag_reg;
    assign out_last    = out_last_reg;

endmodule

// ===== tb/collinear_checker.sv =====
// ----------------------------------------------------------------------------
// collinear_checker
// Watches the configuration, point and kept-point channels of the collinear
// point filter. It keeps its own copy of the anchor, the held candidate and
// the registers, predicts every kept point from the accepted requests, and
// compares each accepted output with the oldest prediction.
// ----------------------------------------------------------------------------
module collinear_checker (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    in_valid,
    input  logic                                                    in_stall,
    input  logic [cpf_pkg::NUM_JOINTS-1:0][cpf_pkg::COORD_W-1:0]    in_joints,
    input  logic [cpf_pkg::TAG_W-1:0]                               point_tag,
    input  logic                                                    last_point,
    input  logic                                                    out_valid,
    input  logic                                                    out_stall,
    input  logic [cpf_pkg::NUM_JOINTS-1:0][cpf_pkg::COORD_W-1:0]    out_joints,
    input  logic [cpf_pkg::TAG_W-1:0]                               out_tag,
    input  logic                                                    out_last,
    input  logic                                                    cfg_valid,
    input  logic                                                    cfg_ready,
    input  logic [cpf_pkg::CFG_IDX_W-1:0]                           cfg_index,
    input  logic [cpf_pkg::CFG_DATA_W-1:0]                          cfg_data,
    output int                                                      errors,
    output int                                                      pending,
    output int                                                      points_taken,
    output int                                                      points_kept
);
    timeunit 1ns;
    timeprecision 1ps;
    import cpf_pkg::*;

    typedef logic [NUM_JOINTS-1:0][COORD_W-1:0] joint_vec_t;

    typedef struct {
        joint_vec_t       joints;
        logic [TAG_W-1:0] tag;
        logic             last;
    } kept_point_t;

    kept_point_t               kept_points_due[$];
    joint_vec_t                anchor_pos;
    joint_vec_t                held_pos;
    logic [TAG_W-1:0]          held_tag;
    phase_t                    fill;
    logic signed [THR_W-1:0]   cos_thr;
    logic [LIM_W-1:0]          short_limit;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit turn_is_straight(input joint_vec_t c);
        longint a, b, n, u, v, p, q, d, lim2, dm, tm;
        logic [255:0] lhs, rhs;
        p = 0;
        q = 0;
        d = 0;
        for (int k = 0; k < NUM_JOINTS; k++)
        begin
            a = $signed(anchor_pos[k]);
            b = $signed(held_pos[k]);
            n = $signed(c[k]);
            u = b - a;
            v = n - b;
            p += u * u;
            q += v * v;
            d += u * v;
        end
        lim2 = longint'(short_limit) * longint'(short_limit);
        if (p <= lim2 || q <= lim2)
            return 1'b1;
        if (d >= 0 && cos_thr <= 0)
            return 1'b1;
        if (d < 0 && cos_thr >= 0)
            return 1'b0;
        dm = d < 0 ? -d : d;
        tm = cos_thr < 0 ? -longint'(cos_thr) : longint'(cos_thr);
        lhs = 256'(dm) * 256'(dm);
        lhs = lhs << CMP_SHIFT;
        rhs = 256'(tm * tm) * 256'(p) * 256'(q);
        if (cos_thr > 0)
            return lhs >= rhs;
        return lhs <= rhs;
    endfunction

    task automatic predict_point(input joint_vec_t c, input logic [TAG_W-1:0] tag,
                                 input logic last);
        kept_point_t kp;
        case (fill)
            PHASE_EMPTY:
            begin
                kp = '{c, tag, last};
                kept_points_due.insert(kept_points_due.size(), kp);
                if (!last)
                begin
                    anchor_pos = c;
                    fill = PHASE_ANCHOR;
                end
            end
            PHASE_ANCHOR:
            begin
                if (last)
                begin
                    kp = '{c, tag, 1'b1};
                    kept_points_due.insert(kept_points_due.size(), kp);
                    fill = PHASE_EMPTY;
                end
                else
                begin
                    held_pos = c;
                    held_tag = tag;
                    fill = PHASE_HELD;
                end
            end
            default:
            begin
                if (!turn_is_straight(c))
                begin
                    kp = '{held_pos, held_tag, 1'b0};
                    kept_points_due.insert(kept_points_due.size(), kp);
                    anchor_pos = held_pos;
                end
                held_pos = c;
                held_tag = tag;
                fill = PHASE_HELD;
                if (last)
                begin
                    kp = '{c, tag, 1'b1};
                    kept_points_due.insert(kept_points_due.size(), kp);
                    fill = PHASE_EMPTY;
                end
            end
        endcase
    endtask

    task automatic compare_kept_point();
        kept_point_t want;
        if (kept_points_due.size() == 0)
        begin
            report_mismatch("kept point with none due, tag", out_tag, 0);
            return;
        end
        want = kept_points_due.pop_front();
        for (int k = 0; k < NUM_JOINTS; k++)
            if (out_joints[k] !== want.joints[k])
                report_mismatch($sformatf("out_joint_%0d", k), out_joints[k], want.joints[k]);
        if (out_tag !== want.tag)
            report_mismatch("out_tag", out_tag, want.tag);
        if (out_last !== want.last)
            report_mismatch("out_last", out_last, want.last);
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        points_taken = 0;
        points_kept = 0;
        fill = PHASE_EMPTY;
        cos_thr = COS_THRESHOLD_RESET;
        short_limit = ZERO_LIMIT_RESET;
        anchor_pos = '0;
        held_pos = '0;
        held_tag = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COS_THRESHOLD)
                    cos_thr = cfg_data;
                else if (cfg_index == REG_ZERO_LENGTH_LIMIT)
                    short_limit = cfg_data[LIM_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                points_taken++;
                predict_point(in_joints, point_tag, last_point);
            end
            if (out_valid && !out_stall)
            begin
                points_kept++;
                compare_kept_point();
            end
        end
        pending = kept_points_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives polylines into the collinear point filter: a short directed set of
// single, two-point, straight, turning and zero-length streams, then random
// near-straight polylines with noise, turns, repeats and wild points, under
// several threshold and length settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_POINTS   = 175;

    typedef logic [NUM_JOINTS-1:0][COORD_W-1:0] joint_vec_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    joint_vec_t              in_joints;
    logic [TAG_W-1:0]        point_tag;
    logic                    last_point;
    logic                    out_valid;
    logic                    out_stall;
    joint_vec_t              out_joints;
    logic [TAG_W-1:0]        out_tag;
    logic                    out_last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int errors;
    int pending;
    int points_taken;
    int points_kept;
    int idle_pct;
    int stall_pct;
    logic hold_off;
    int quiet_cycles;

    collinear_point_filter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .joint_0     (in_joints[0]),
        .joint_1     (in_joints[1]),
        .joint_2     (in_joints[2]),
        .joint_3     (in_joints[3]),
        .joint_4     (in_joints[4]),
        .joint_5     (in_joints[5]),
        .point_tag   (point_tag),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_joint_0 (out_joints[0]),
        .out_joint_1 (out_joints[1]),
        .out_joint_2 (out_joints[2]),
        .out_joint_3 (out_joints[3]),
        .out_joint_4 (out_joints[4]),
        .out_joint_5 (out_joints[5]),
        .out_tag     (out_tag),
        .out_last    (out_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    collinear_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_joints    (in_joints),
        .point_tag    (point_tag),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_joints   (out_joints),
        .out_tag      (out_tag),
        .out_last     (out_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .points_taken (points_taken),
        .points_kept  (points_kept)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input joint_vec_t pos, input logic [TAG_W-1:0] tag,
                              input logic last);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_joints  <= pos;
        point_tag  <= tag;
        last_point <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic joint_vec_t fill_all(input logic [COORD_W-1:0] value);
        joint_vec_t r;
        for (int k = 0; k < NUM_JOINTS; k++)
            r[k] = value;
        return r;
    endfunction

    function automatic joint_vec_t wild_point();
        joint_vec_t r;
        for (int k = 0; k < NUM_JOINTS; k++)
            r[k] = COORD_W'($urandom());
        return r;
    endfunction

    task automatic directed_points();
        joint_vec_t lo, hi, z, step;
        lo = fill_all(24'h800000);
        hi = fill_all(24'h7fffff);
        z  = '0;
        step = fill_all(24'h000400);
        send_point(lo, 16'h0000, 1'b1);
        send_point(hi, 16'hffff, 1'b1);
        send_point(lo, 16'h0001, 1'b0);
        send_point(hi, 16'h0002, 1'b1);
        send_point(z, 16'h0010, 1'b0);
        send_point(step, 16'h0011, 1'b0);
        send_point(step + step, 16'h0012, 1'b0);
        send_point(step + step, 16'h0013, 1'b0);
        send_point(step * 3, 16'h0014, 1'b0);
        send_point(z, 16'h0015, 1'b1);
        send_point(z, 16'h0020, 1'b0);
        send_point(hi, 16'h0021, 1'b0);
        send_point(lo, 16'h0022, 1'b0);
        send_point(hi, 16'h0023, 1'b0);
        send_point(wild_point(), 16'h5a5a, 1'b1);
        send_point(z, 16'h0030, 1'b0);
        send_point(fill_all(24'h100000), 16'h0031, 1'b0);
        send_point(fill_all(24'h100001), 16'h0032, 1'b1);
    endtask

    task automatic random_polylines(input int count);
        joint_vec_t pos, dir;
        int len, scale, noise, sent;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(24, 4);
            scale = $urandom_range(20);
            noise = $urandom_range(3) == 0 ? 0 : (1 << $urandom_range(scale));
            pos = ($urandom_range(7) == 0) ? wild_point()
                                           : fill_all(COORD_W'($urandom_range(4095)));
            for (int k = 0; k < NUM_JOINTS; k++)
                dir[k] = COORD_W'($urandom_range(1 << scale)
                                  - (1 << (scale - (scale > 0))));
            for (int i = 0; i < len; i++)
            begin
                send_point(pos, TAG_W'($urandom()), i == len - 1);
                sent++;
                case ($urandom_range(19))
                    0: pos = wild_point();
                    1, 2: ;
                    3, 4:
                        for (int k = 0; k < NUM_JOINTS; k++)
                            dir[k] = COORD_W'($urandom_range(1 << scale)
                                              - (1 << (scale - (scale > 0))));
                    default:
                        for (int k = 0; k < NUM_JOINTS; k++)
                            pos[k] = COORD_W'(pos[k] + dir[k] + $urandom_range(noise)
                                              - noise / 2);
                endcase
            end
        end
    endtask

    initial
    begin
        logic signed [THR_W-1:0] thr_set [7];
        logic [LIM_W-1:0] lim_set [7];
        thr_set = '{32'sd1073688042, 32'sd1073741824, -32'sd1073741824, 32'sd0,
                    32'sh7fffffff, 32'sh80000000, 32'sd0};
        lim_set = '{20'd1, 20'd0, 20'hfffff, 20'd1000, 20'd5, 20'd0, 20'd0};
        thr_set[6] = $urandom_range(2147483647) - 32'sd1073741824;
        lim_set[6] = LIM_W'($urandom_range(255));
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_joints = '0;
        point_tag = '0;
        last_point = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_COS_THRESHOLD;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_points();
        for (int ph = 0; ph < 7; ph++)
        begin
            drain_and_settle();
            write_reg(REG_COS_THRESHOLD, thr_set[ph]);
            write_reg(REG_ZERO_LENGTH_LIMIT, {12'($urandom()), lim_set[ph]});
            idle_pct  = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 25 : 0;
            stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 25 : 0;
            if (ph == 2)
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            random_polylines(PHASE_POINTS);
        end
        drain_and_settle();
        $display("Run covered %0d points and %0d kept points over 7 register settings,",
                 points_taken, points_kept);
        $display("with idle and stall patterns and one long output hold-off.");
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
